@@ rtl/pstd_pkg.sv @@
// ----------------------------------------------------------------------------
// pstd_pkg: shared types and marker table for the packstream token decoder
// Token kinds, decode phases and the marker classification function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pstd_pkg;

   localparam int unsigned ValueWidth   = 64;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned PayloadWidth = 32;

   // Marker table boundaries
   localparam logic [7:0] MARKER_TINY_STRING = 8'h80;
   localparam logic [7:0] MARKER_TINY_LIST   = 8'h90;
   localparam logic [7:0] MARKER_TINY_MAP    = 8'hA0;
   localparam logic [7:0] MARKER_TINY_STRUCT = 8'hB0;
   localparam logic [7:0] MARKER_NULL        = 8'hC0;
   localparam logic [7:0] MARKER_FLOAT       = 8'hC1;
   localparam logic [7:0] MARKER_FALSE       = 8'hC2;
   localparam logic [7:0] MARKER_TRUE        = 8'hC3;
   localparam logic [7:0] MARKER_INT_8       = 8'hC8;
   localparam logic [7:0] MARKER_INT_64      = 8'hCB;
   localparam logic [7:0] MARKER_BYTES_8     = 8'hCC;
   localparam logic [7:0] MARKER_BYTES_32    = 8'hCE;
   localparam logic [7:0] MARKER_STRING_8    = 8'hD0;
   localparam logic [7:0] MARKER_STRING_32   = 8'hD2;
   localparam logic [7:0] MARKER_LIST_8      = 8'hD4;
   localparam logic [7:0] MARKER_LIST_32     = 8'hD6;
   localparam logic [7:0] MARKER_MAP_8       = 8'hD8;
   localparam logic [7:0] MARKER_MAP_32      = 8'hDA;
   localparam logic [7:0] MARKER_NEG_TINY    = 8'hF0;

   localparam logic [CountWidth-1:0] FLOAT_BYTES = 4'd8;

   typedef enum logic [3:0] {
      KIND_UNDEF   = 4'd0,
      KIND_NULL    = 4'd1,
      KIND_FALSE   = 4'd2,
      KIND_TRUE    = 4'd3,
      KIND_INT     = 4'd4,
      KIND_FLOAT   = 4'd5,
      KIND_BYTES   = 4'd6,
      KIND_STRING  = 4'd7,
      KIND_LIST    = 4'd8,
      KIND_MAP     = 4'd9,
      KIND_STRUCT  = 4'd10,
      KIND_PAYLOAD = 4'd11
   } token_kind_type;

   typedef enum logic [1:0] {
      PHASE_MARKER  = 2'd0,
      PHASE_HEADER  = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      token_kind_type              kind;
      logic [ValueWidth-1:0]       value;
      logic [CountWidth-1:0]       follow;
   } marker_class_type;

   // Classify one marker byte: kind, immediate value, count of following bytes.
   function automatic marker_class_type classify_marker(input logic [7:0] marker);
      marker_class_type cls;
      cls.kind   = KIND_UNDEF;
      cls.value  = '0;
      cls.follow = '0;
      case (marker) inside
         [8'h00 : MARKER_TINY_STRING - 8'd1]: begin
            cls.kind  = KIND_INT;
            cls.value = {56'd0, marker};
         end
         [MARKER_TINY_STRING : MARKER_TINY_LIST - 8'd1]: begin
            cls.kind  = KIND_STRING;
            cls.value = {60'd0, marker[3:0]};
         end
         [MARKER_TINY_LIST : MARKER_TINY_MAP - 8'd1]: begin
            cls.kind  = KIND_LIST;
            cls.value = {60'd0, marker[3:0]};
         end
         [MARKER_TINY_MAP : MARKER_TINY_STRUCT - 8'd1]: begin
            cls.kind  = KIND_MAP;
            cls.value = {60'd0, marker[3:0]};
         end
         [MARKER_TINY_STRUCT : MARKER_NULL - 8'd1]: begin
            cls.kind  = KIND_STRUCT;
            cls.value = {60'd0, marker[3:0]};
         end
         [MARKER_NEG_TINY : 8'hFF]: begin
            cls.kind  = KIND_INT;
            cls.value = {{56{1'b1}}, marker};
         end
         MARKER_NULL:  cls.kind = KIND_NULL;
         MARKER_FLOAT: begin
            cls.kind   = KIND_FLOAT;
            cls.follow = FLOAT_BYTES;
         end
         MARKER_FALSE: cls.kind = KIND_FALSE;
         MARKER_TRUE:  cls.kind = KIND_TRUE;
         [MARKER_INT_8 : MARKER_INT_64]: begin
            cls.kind   = KIND_INT;
            cls.follow = 4'd1 << marker[1:0];
         end
         [MARKER_BYTES_8 : MARKER_BYTES_32]: begin
            cls.kind   = KIND_BYTES;
            cls.follow = 4'd1 << marker[1:0];
         end
         [MARKER_STRING_8 : MARKER_STRING_32]: begin
            cls.kind   = KIND_STRING;
            cls.follow = 4'd1 << marker[1:0];
         end
         [MARKER_LIST_8 : MARKER_LIST_32]: begin
            cls.kind   = KIND_LIST;
            cls.follow = 4'd1 << marker[1:0];
         end
         [MARKER_MAP_8 : MARKER_MAP_32]: begin
            cls.kind   = KIND_MAP;
            cls.follow = 4'd1 << marker[1:0];
         end
         default: cls.kind = KIND_UNDEF;
      endcase
      return cls;
   endfunction

endpackage

@@ rtl/pstd_req_if.sv @@
// ----------------------------------------------------------------------------
// pstd_req_if: input byte channel
// Valid/ready channel carrying one serialized byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pstd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

@@ rtl/pstd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pstd_rsp_if: token result channel
// Valid/ready channel carrying one decoded token with its status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pstd_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         token_kind;
   logic signed [63:0] token_value;
   logic               error_code;
   logic               last;

   modport source (output valid, output token_kind, output token_value,
                   output error_code, output last, input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input error_code, input last, output ready);
endinterface

@@ rtl/packstream_token_decoder.sv @@
// ----------------------------------------------------------------------------
// packstream_token_decoder: byte-serial token decoder
// A token appears on rsp in the cycle after the transfer of the byte that
// completes it. Throughput: one byte per cycle unless rsp back-pressure stalls
// the input, set by the single decode stage feeding the output register; header
// bytes that finish nothing yield no token. Reset (synchronous, active high)
// returns the decoder to expect a marker byte and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packstream_token_decoder
   import pstd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pstd_req_if.sink    req_ch,
   pstd_rsp_if.source  rsp_ch
);

   // Decode state
   phase_type                 phase_ff,        phase_in;
   token_kind_type            pending_kind_ff, pending_kind_in;
   logic [CountWidth-1:0]     field_width_ff,  field_width_in;
   logic [CountWidth-1:0]     bytes_left_ff,   bytes_left_in;
   logic [ValueWidth-1:0]     accumulator_ff,  accumulator_in;
   logic [PayloadWidth-1:0]   payload_left_ff, payload_left_in;

   // Output register
   logic                      rsp_valid_ff;
   token_kind_type            rsp_kind_ff,  rsp_kind_in;
   logic [ValueWidth-1:0]     rsp_value_ff, rsp_value_in;
   logic                      rsp_error_ff, rsp_error_in;
   logic                      rsp_last_ff,  rsp_last_in;

   logic                      req_transfer;
   logic                      emit;
   logic [7:0]                in_byte;
   logic                      buffer_end;
   marker_class_type          marker_class;
   logic [ValueWidth-1:0]     header_acc;
   logic [ValueWidth-1:0]     header_value;
   logic [PayloadWidth-1:0]   payload_dec;

   // Take a new byte whenever the output register is empty or being drained.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_transfer = req_ch.valid && req_ch.ready;
   assign in_byte      = req_ch.in_byte;
   assign buffer_end   = req_ch.buffer_end;

   assign marker_class = classify_marker(in_byte);

   // Shift the header byte in, big-endian.
   assign header_acc = {accumulator_ff[ValueWidth-9:0], in_byte};

   // Sign-extend short integer headers; lengths and floats stay unsigned.
   always_comb begin
      header_value = header_acc;
      if (pending_kind_ff == KIND_INT) begin
         case (field_width_ff)
            4'd1:    header_value = {{56{header_acc[7]}},  header_acc[7:0]};
            4'd2:    header_value = {{48{header_acc[15]}}, header_acc[15:0]};
            4'd4:    header_value = {{32{header_acc[31]}}, header_acc[31:0]};
            default: header_value = header_acc;
         endcase
      end
   end

   assign payload_dec = payload_left_ff - PayloadWidth'(payload_left_ff != '0);

   // Next state and token for the byte at the input.
   always_comb begin
      logic                  do_clear;
      logic                  finish;
      logic                  enter_header;
      logic                  has_payload;
      token_kind_type        fin_kind;
      logic [ValueWidth-1:0] fin_value;

      do_clear     = 1'b0;
      finish       = 1'b0;
      enter_header = 1'b0;
      has_payload  = 1'b0;
      fin_kind     = KIND_UNDEF;
      fin_value    = '0;

      phase_in        = phase_ff;
      pending_kind_in = pending_kind_ff;
      field_width_in  = field_width_ff;
      bytes_left_in   = bytes_left_ff;
      accumulator_in  = accumulator_ff;
      payload_left_in = payload_left_ff;

      emit         = 1'b0;
      rsp_kind_in  = KIND_UNDEF;
      rsp_value_in = '0;
      rsp_error_in = 1'b0;
      rsp_last_in  = buffer_end;

      case (phase_ff)
         PHASE_HEADER: begin
            accumulator_in = header_acc;
            bytes_left_in  = bytes_left_ff - CountWidth'(bytes_left_ff != '0);
            if (bytes_left_ff <= 4'd1) begin
               finish    = 1'b1;
               fin_kind  = pending_kind_ff;
               fin_value = header_value;
            end else if (buffer_end) begin
               // Buffer cut the header short: flag it with the pending kind.
               emit         = 1'b1;
               rsp_kind_in  = pending_kind_ff;
               rsp_error_in = 1'b1;
               do_clear     = 1'b1;
            end
         end
         PHASE_PAYLOAD: begin
            payload_left_in = payload_dec;
            emit            = 1'b1;
            rsp_kind_in     = KIND_PAYLOAD;
            rsp_value_in    = {56'd0, in_byte};
            if (payload_dec == '0) begin
               do_clear = 1'b1;
            end else if (buffer_end) begin
               rsp_error_in = 1'b1;
            end
            if (buffer_end) begin
               do_clear = 1'b1;
            end
         end
         default: begin
            // Marker byte; the unused phase code lands here too.
            if (marker_class.follow == '0) begin
               finish    = 1'b1;
               fin_kind  = marker_class.kind;
               fin_value = marker_class.value;
            end else if (buffer_end) begin
               emit         = 1'b1;
               rsp_kind_in  = marker_class.kind;
               rsp_error_in = 1'b1;
               do_clear     = 1'b1;
            end else begin
               do_clear     = 1'b1;
               enter_header = 1'b1;
            end
         end
      endcase

      if (finish) begin
         has_payload  = ((fin_kind == KIND_STRING) || (fin_kind == KIND_BYTES))
                        && (fin_value != '0);
         emit         = 1'b1;
         rsp_kind_in  = fin_kind;
         rsp_value_in = fin_value;
         rsp_error_in = buffer_end && has_payload;
         do_clear     = 1'b1;
      end

      if (do_clear) begin
         phase_in        = PHASE_MARKER;
         pending_kind_in = KIND_UNDEF;
         field_width_in  = '0;
         bytes_left_in   = '0;
         accumulator_in  = '0;
         payload_left_in = '0;
      end

      // Open the payload phase after a nonzero string or bytes length, unless the buffer ends.
      if (finish && has_payload && !buffer_end) begin
         phase_in        = PHASE_PAYLOAD;
         payload_left_in = fin_value[PayloadWidth-1:0];
      end

      if (enter_header) begin
         phase_in        = PHASE_HEADER;
         pending_kind_in = marker_class.kind;
         field_width_in  = marker_class.follow;
         bytes_left_in   = marker_class.follow;
      end
   end

   // Advance decode state on every byte transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_MARKER;
         pending_kind_ff <= KIND_UNDEF;
         field_width_ff  <= '0;
         bytes_left_ff   <= '0;
         accumulator_ff  <= '0;
         payload_left_ff <= '0;
      end else if (req_transfer) begin
         phase_ff        <= phase_in;
         pending_kind_ff <= pending_kind_in;
         field_width_ff  <= field_width_in;
         bytes_left_ff   <= bytes_left_in;
         accumulator_ff  <= accumulator_in;
         payload_left_ff <= payload_left_in;
      end
   end

   // Hold a token until its transfer; load a new one with each byte that yields one.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer && emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.token_kind  = rsp_kind_ff;
   assign rsp_ch.token_value = $signed(rsp_value_ff);
   assign rsp_ch.error_code  = rsp_error_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

@@ tb/pstd_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_token_checker: token scoreboard for the packstream decoder
// Watches the byte and token channels. It decodes every accepted byte with its
// own model of the decoder and compares each accepted token with the oldest
// prediction.
// ----------------------------------------------------------------------------

module pstd_token_checker
   import pstd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pstd_req_if         req_ch,
   pstd_rsp_if         rsp_ch,
   output int unsigned fail_count,
   output int unsigned tokens_outstanding
);

   typedef struct packed {
      token_kind_type kind;
      logic [63:0]    value;
      logic           error_code;
      logic           last;
   } token_type;

   token_type      predicted_tokens[$];

   // decoder model state
   phase_type      phase;
   token_kind_type header_kind;
   logic [3:0]     header_width;
   logic [3:0]     header_left;
   logic [63:0]    header_acc;
   logic [31:0]    payload_left;
   int unsigned    errors = 0;

   function automatic void clear_decoder();
      phase        = PHASE_MARKER;
      header_kind  = KIND_UNDEF;
      header_width = '0;
      header_left  = '0;
      header_acc   = '0;
      payload_left = '0;
   endfunction

   // Append one predicted token at the tail of the queue.
   function automatic void queue_token(input token_kind_type k, input logic [63:0] v,
                                       input logic err, input logic fin);
      token_type tok;
      tok.kind       = k;
      tok.value      = v;
      tok.error_code = err;
      tok.last       = fin;
      predicted_tokens.insert(predicted_tokens.size(), tok);
   endfunction

   // Marker table: kind, immediate value and count of header bytes.
   function automatic void sort_marker(input logic [7:0] m, output token_kind_type k,
                                       output logic [63:0] v, output logic [3:0] follow);
      k      = KIND_UNDEF;
      v      = '0;
      follow = '0;
      if (m < MARKER_TINY_STRING) begin
         k = KIND_INT;
         v = 64'(m);
      end else if (m < MARKER_TINY_LIST) begin
         k = KIND_STRING;
         v = 64'(m - MARKER_TINY_STRING);
      end else if (m < MARKER_TINY_MAP) begin
         k = KIND_LIST;
         v = 64'(m - MARKER_TINY_LIST);
      end else if (m < MARKER_TINY_STRUCT) begin
         k = KIND_MAP;
         v = 64'(m - MARKER_TINY_MAP);
      end else if (m < MARKER_NULL) begin
         k = KIND_STRUCT;
         v = 64'(m - MARKER_TINY_STRUCT);
      end else if (m >= MARKER_NEG_TINY) begin
         k = KIND_INT;
         v = {{56{1'b1}}, m};
      end else if (m == MARKER_NULL) begin
         k = KIND_NULL;
      end else if (m == MARKER_FLOAT) begin
         k      = KIND_FLOAT;
         follow = FLOAT_BYTES;
      end else if (m == MARKER_FALSE) begin
         k = KIND_FALSE;
      end else if (m == MARKER_TRUE) begin
         k = KIND_TRUE;
      end else if (m >= MARKER_INT_8 && m <= MARKER_INT_64) begin
         k      = KIND_INT;
         follow = 4'd1 << (m - MARKER_INT_8);
      end else if (m >= MARKER_BYTES_8 && m <= MARKER_BYTES_32) begin
         k      = KIND_BYTES;
         follow = 4'd1 << (m - MARKER_BYTES_8);
      end else if (m >= MARKER_STRING_8 && m <= MARKER_STRING_32) begin
         k      = KIND_STRING;
         follow = 4'd1 << (m - MARKER_STRING_8);
      end else if (m >= MARKER_LIST_8 && m <= MARKER_LIST_32) begin
         k      = KIND_LIST;
         follow = 4'd1 << (m - MARKER_LIST_8);
      end else if (m >= MARKER_MAP_8 && m <= MARKER_MAP_32) begin
         k      = KIND_MAP;
         follow = 4'd1 << (m - MARKER_MAP_8);
      end
   endfunction

   // Emit a finished token; a nonempty string or byte array opens the payload unless the buffer ends.
   function automatic void complete_token(input token_kind_type k, input logic [63:0] v,
                                          input logic fin);
      logic has_payload;
      has_payload = (k == KIND_STRING || k == KIND_BYTES) && v != 0;
      clear_decoder();
      if (fin) begin
         queue_token(k, v, has_payload, 1'b1);
      end else begin
         if (has_payload) begin
            phase        = PHASE_PAYLOAD;
            payload_left = v[31:0];
         end
         queue_token(k, v, 1'b0, 1'b0);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic fin);
      token_kind_type k;
      logic [63:0]    v;
      logic [3:0]     follow;
      logic           err;
      case (phase)
         PHASE_HEADER: begin
            header_acc = {header_acc[55:0], b};
            if (header_left != 0) header_left--;
            if (header_left == 0) begin
               v = header_acc;
               if (header_kind == KIND_INT) begin
                  case (header_width)
                     4'd1: v = {{56{header_acc[7]}}, header_acc[7:0]};
                     4'd2: v = {{48{header_acc[15]}}, header_acc[15:0]};
                     4'd4: v = {{32{header_acc[31]}}, header_acc[31:0]};
                     default: v = header_acc;
                  endcase
               end
               complete_token(header_kind, v, fin);
            end else if (fin) begin
               queue_token(header_kind, 64'd0, 1'b1, 1'b1);
               clear_decoder();
            end
         end
         PHASE_PAYLOAD: begin
            err = 1'b0;
            if (payload_left != 0) payload_left--;
            if (payload_left == 0) clear_decoder();
            else if (fin) err = 1'b1;
            queue_token(KIND_PAYLOAD, 64'(b), err, fin);
            if (fin) clear_decoder();
         end
         default: begin
            sort_marker(b, k, v, follow);
            if (follow == 0) begin
               complete_token(k, v, fin);
            end else if (fin) begin
               // buffer ends on a marker that still needs header bytes
               queue_token(k, 64'd0, 1'b1, 1'b1);
               clear_decoder();
            end else begin
               clear_decoder();
               phase        = PHASE_HEADER;
               header_kind  = k;
               header_width = follow;
               header_left  = follow;
            end
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      $display("%0t: token %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
   endfunction

   function automatic void compare_token();
      token_type want;
      if (predicted_tokens.size() == 0) begin
         $display("%0t: unexpected token, expected none, actual kind %0d value %h",
                  $time, rsp_ch.token_kind, rsp_ch.token_value);
         errors++;
         return;
      end
      want = predicted_tokens.pop_front();
      if (rsp_ch.token_kind !== want.kind)
         note_mismatch("kind", 64'(want.kind), 64'(rsp_ch.token_kind));
      if (rsp_ch.token_value !== want.value)
         note_mismatch("value", want.value, rsp_ch.token_value);
      if (rsp_ch.error_code !== want.error_code)
         note_mismatch("error_code", 64'(want.error_code), 64'(rsp_ch.error_code));
      if (rsp_ch.last !== want.last)
         note_mismatch("last", 64'(want.last), 64'(rsp_ch.last));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         predicted_tokens.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) compare_token();
         if (req_ch.valid && req_ch.ready) decode_byte(req_ch.in_byte, req_ch.buffer_end);
      end
      fail_count         <= errors;
      tokens_outstanding <= predicted_tokens.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the packstream token decoder
// Feeds a directed byte sequence and then random buffers (well-formed values,
// truncated buffers and raw noise) under three idling regimes. The checker
// beside the decoder predicts and compares every token; this module only
// drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_top
   import pstd_pkg::*;
();

   localparam int unsigned RandomBytes = 1300;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned CycleLimit  = 200000;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } stream_byte_type;

   logic            clock = 1'b0;
   logic            reset;
   int unsigned     fail_count;
   int unsigned     tokens_outstanding;
   int unsigned     cycle_count = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;

   stream_byte_type byte_stream[$];
   logic [7:0]      frame[$];

   pstd_req_if req_ch();
   pstd_rsp_if rsp_ch();

   packstream_token_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pstd_token_checker scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req_ch             (req_ch),
      .rsp_ch             (rsp_ch),
      .fail_count         (fail_count),
      .tokens_outstanding (tokens_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the token channel at the rate of the current regime.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic fin);
      stream_byte_type item;
      item.data = b;
      item.fin  = fin;
      byte_stream.insert(byte_stream.size(), item);
   endtask

   // Append one byte to the frame under construction.
   task automatic put_frame_byte(input logic [7:0] b);
      frame.insert(frame.size(), b);
   endtask

   // Append a big-endian header field of the given byte count.
   task automatic push_field(input logic [31:0] v, input int unsigned nbytes);
      for (int i = nbytes - 1; i >= 0; i--) put_frame_byte(8'(v >> (8 * i)));
   endtask

   // Append one well-formed value to the frame under construction.
   task automatic add_value();
      int unsigned sel, w, len, r;
      sel = $urandom_range(0, 11);
      case (sel)
         0: put_frame_byte(8'($urandom_range(0, MARKER_TINY_STRING - 1)));
         1: put_frame_byte(8'($urandom_range(MARKER_NEG_TINY, 8'hFF)));
         2: begin
            r = $urandom_range(0, 2);
            put_frame_byte(r == 0 ? MARKER_NULL : (r == 1 ? MARKER_FALSE : MARKER_TRUE));
         end
         3: begin
            put_frame_byte(MARKER_FLOAT);
            repeat (FLOAT_BYTES) put_frame_byte(8'($urandom_range(0, 255)));
         end
         4: begin
            w = $urandom_range(0, 3);
            put_frame_byte(8'(MARKER_INT_8 + w));
            repeat (1 << w) put_frame_byte(8'($urandom_range(0, 255)));
         end
         5, 6: begin
            // mostly short payloads, now and then a longer one
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            if (sel == 5 && len < 16 && $urandom_range(0, 1) == 1) begin
               put_frame_byte(8'(MARKER_TINY_STRING + len));
            end else begin
               w = $urandom_range(0, 2);
               put_frame_byte(8'((sel == 5 ? MARKER_STRING_8 : MARKER_BYTES_8) + w));
               push_field(len, 1 << w);
            end
            repeat (len) put_frame_byte(8'($urandom_range(0, 255)));
         end
         7: begin
            r = $urandom_range(0, 2);
            put_frame_byte(8'((r == 0 ? MARKER_TINY_LIST :
                              (r == 1 ? MARKER_TINY_MAP : MARKER_TINY_STRUCT))
                              + $urandom_range(0, 15)));
         end
         8: begin
            w = $urandom_range(0, 2);
            put_frame_byte(8'(($urandom_range(0, 1) ? MARKER_LIST_8 : MARKER_MAP_8) + w));
            push_field($urandom(), 1 << w);
         end
         9: begin
            // markers outside the table: the gaps after true, bytes, string,
            // list and map headers
            r = $urandom_range(0, 27);
            if (r < 4) put_frame_byte(8'(MARKER_TRUE + 1 + r));
            else if (r == 4) put_frame_byte(MARKER_BYTES_32 + 8'd1);
            else if (r == 5) put_frame_byte(MARKER_STRING_32 + 8'd1);
            else if (r == 6) put_frame_byte(MARKER_LIST_32 + 8'd1);
            else put_frame_byte(8'(MARKER_MAP_32 + 1 + (r - 7)));
         end
         default: begin
            // integer extremes: zero, minus one, most negative, most positive
            w = $urandom_range(0, 3);
            r = $urandom_range(0, 3);
            put_frame_byte(8'(MARKER_INT_8 + w));
            for (int i = 0; i < (1 << w); i++) begin
               if (r == 0) put_frame_byte(8'h00);
               else if (r == 1) put_frame_byte(8'hFF);
               else if (r == 2) put_frame_byte(i == 0 ? 8'h80 : 8'h00);
               else put_frame_byte(i == 0 ? 8'h7F : 8'hFF);
            end
         end
      endcase
   endtask

   // Append one buffer: whole, cut short, or raw noise with stray ends.
   task automatic add_frame();
      int unsigned mode, cut;
      mode = $urandom_range(0, 99);
      frame.delete();
      if (mode < 80) begin
         repeat ($urandom_range(1, 6)) add_value();
         cut = (mode < 65) ? frame.size() : $urandom_range(1, frame.size());
      end else begin
         repeat ($urandom_range(1, 12)) put_frame_byte(8'($urandom_range(0, 255)));
         cut = frame.size();
      end
      for (int i = 0; i < cut; i++)
         add_byte(frame[i], (mode < 80) ? (i == cut - 1) : ($urandom_range(0, 7) == 0));
   endtask

   // Offer one byte; idle first at the current rate, then hold until transfer.
   task automatic send_byte(input stream_byte_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= item.data;
      req_ch.buffer_end <= item.fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   initial begin
      int unsigned directed_count, third;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.in_byte    <= 8'h00;
      req_ch.buffer_end <= 1'b0;

      // Directed: field extremes, every fixed marker, and the special cases.
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(MARKER_NEG_TINY, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(MARKER_NULL, 1'b0);
      add_byte(MARKER_FALSE, 1'b0);
      add_byte(MARKER_TRUE, 1'b0);
      add_byte(MARKER_TRUE + 8'd1, 1'b0);          // unknown marker
      add_byte(MARKER_TINY_STRING, 1'b0);          // empty tiny string
      add_byte(MARKER_INT_8, 1'b0);
      add_byte(8'h80, 1'b0);                       // sign-extends to -128
      add_byte(MARKER_STRING_8, 1'b0);
      add_byte(8'h00, 1'b0);                       // empty string, no payload
      add_byte(MARKER_TINY_STRING + 8'd1, 1'b0);
      add_byte(8'h41, 1'b0);                       // single payload byte
      add_byte(MARKER_TINY_STRUCT + 8'd15, 1'b0);
      add_byte(MARKER_TINY_LIST + 8'd15, 1'b0);
      add_byte(MARKER_TINY_MAP + 8'd15, 1'b1);
      add_byte(MARKER_BYTES_8, 1'b0);
      add_byte(8'h02, 1'b1);                       // end right after a payload header
      add_byte(MARKER_INT_8 + 8'd1, 1'b1);         // end on a marker needing header
      add_byte(MARKER_TINY_STRING + 8'd2, 1'b0);
      add_byte(8'h41, 1'b1);                       // end with payload still due
      add_byte(MARKER_FLOAT, 1'b0);
      add_byte(8'h00, 1'b1);                       // end inside a float header
      directed_count = byte_stream.size();

      while (byte_stream.size() < directed_count + RandomBytes) add_frame();
      third = (byte_stream.size() - directed_count) / 3;

      // Hold reset, then drop it for good.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < byte_stream.size(); i++) begin
         // Advance through the idling regimes: sender dense / receiver heavy,
         // then the reverse, then full rate on both sides.
         if (i == directed_count) begin
            send_idle_pct  = 9;
            recv_stall_pct = 76;
         end else if (i == directed_count + third) begin
            send_idle_pct  = 76;
            recv_stall_pct = 9;
         end else if (i == directed_count + 2 * third) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         send_byte(byte_stream[i]);
      end
      req_ch.valid <= 1'b0;

      // Wait for every predicted token, then drain for stray ones.
      do @(posedge clock); while (tokens_outstanding != 0);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0 && tokens_outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ packstream_token_decoder.f @@
rtl/pstd_pkg.sv
rtl/pstd_req_if.sv
rtl/pstd_rsp_if.sv
rtl/packstream_token_decoder.sv
tb/pstd_token_checker.sv
tb/tb_top.sv
